// ===== design/ir_frame_decoder_crc16_top_macros.svh =====
// assertion macros used by the checker file of the frame decoder
`ifndef IR_FRAME_DECODER_CRC16_TOP_MACROS_SVH
`define IR_FRAME_DECODER_CRC16_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define IFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define IFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ifd_pkg.sv =====
// package: constants, payload types, control structs and crc step for the frame decoder
`timescale 1ns / 1ps

package ifd_pkg;

    localparam int CHANNELS  = 16;
    localparam int CRC_SPAN  = 3 + 2 * CHANNELS;
    localparam int STORE_LEN = 1 + 2 * CHANNELS;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW        = $clog2(STORE_LEN);

    localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
    localparam logic [7:0]  SYNC_SECOND = 8'h5A;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [63:0] time_ms;
    } t_in;

    typedef struct packed {
        logic [7:0]  frame_sequence;
        logic [3:0]  channel_index;
        logic [15:0] channel_strength;
        logic [63:0] received_time;
        logic        last_channel;
    } t_out;

    typedef enum logic [2:0] {
        S_HUNT,
        S_SYNC,
        S_BODY,
        S_CRC_LO,
        S_CRC_HI,
        S_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic crc_first;
        logic crc_next;
        logic crc_init;
        logic pos_clear;
        logic store;
        logic lo_load;
        logic accept;
        logic ch_clear;
        logic emit_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_first;
        logic is_second;
        logic body_last;
        logic frame_good;
        logic ch_last;
        logic out_free;
    } t_sts;

    // one byte of crc-16/ccitt-false, msb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== design/ifd_ctrl.sv =====
// controller state machine of the frame decoder
`timescale 1ns / 1ps

module ifd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  ifd_pkg::t_sts i_sts,
    output ifd_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);
    import ifd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_acc;

    assign o_in_stall = (r_state == S_EMIT);
    assign in_acc     = i_in_valid && (r_state != S_EMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_HUNT: begin
                if (in_acc && i_sts.is_first) n_state = S_SYNC;
            end
            S_SYNC: begin
                if (in_acc) begin
                    if (i_sts.is_second)     n_state = S_BODY;
                    else if (!i_sts.is_first) n_state = S_HUNT;
                end
            end
            S_BODY: begin
                if (in_acc && i_sts.body_last) n_state = S_CRC_LO;
            end
            S_CRC_LO: begin
                if (in_acc) n_state = S_CRC_HI;
            end
            S_CRC_HI: begin
                if (in_acc) n_state = i_sts.frame_good ? S_EMIT : S_HUNT;
            end
            S_EMIT: begin
                if (i_sts.out_free && i_sts.ch_last) n_state = S_HUNT;
            end
            default: n_state = S_HUNT;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_HUNT: begin
                o_cmd.crc_first = in_acc && i_sts.is_first;
            end
            S_SYNC: begin
                o_cmd.crc_next  = in_acc && i_sts.is_second;
                o_cmd.pos_clear = in_acc && i_sts.is_second;
                o_cmd.crc_first = in_acc && !i_sts.is_second && i_sts.is_first;
                o_cmd.crc_init  = in_acc && !i_sts.is_second && !i_sts.is_first;
            end
            S_BODY: begin
                o_cmd.store    = in_acc;
                o_cmd.crc_next = in_acc;
            end
            S_CRC_LO: begin
                o_cmd.lo_load = in_acc;
            end
            S_CRC_HI: begin
                o_cmd.crc_init = in_acc;
                o_cmd.accept   = in_acc && i_sts.frame_good;
                o_cmd.ch_clear = in_acc && i_sts.frame_good;
            end
            S_EMIT: begin
                o_cmd.emit_load = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== design/ifd_datapath.sv =====
// datapath of the frame decoder: crc, strength memory, frame registers, output register
`timescale 1ns / 1ps

module ifd_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ifd_pkg::t_in    i_in_data,
    input  ifd_pkg::t_cmd   i_cmd,
    output ifd_pkg::t_sts   o_sts,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output ifd_pkg::t_out   o_out_data
);
    import ifd_pkg::*;

    logic [15:0]     r_mem [CHANNELS];
    logic [15:0]     r_rd;
    logic [15:0]     r_crc;
    logic [PW-1:0]   r_pos;
    logic [CH_W-1:0] r_ch;
    logic [CH_W-1:0] n_ch;
    logic [7:0]      r_lo;
    logic [7:0]      r_crc_lo;
    logic [7:0]      r_seq_frame;
    logic [7:0]      r_last_seq;
    logic            r_seen;
    logic [63:0]     r_time;
    logic            r_ovalid;
    t_out            r_out;
    logic [7:0]      b;
    logic [PW-1:0]   half_pos;
    logic [CH_W-1:0] widx;

    assign b        = i_in_data.data_byte;
    assign half_pos = (r_pos >> 1) - PW'(1);
    assign widx     = half_pos[CH_W-1:0];

    assign o_sts.is_first   = (b == SYNC_FIRST);
    assign o_sts.is_second  = (b == SYNC_SECOND);
    assign o_sts.body_last  = (r_pos == PW'(STORE_LEN - 1));
    assign o_sts.frame_good = (r_crc == {b, r_crc_lo}) &&
                              !(r_seen && (r_seq_frame == r_last_seq));
    assign o_sts.ch_last    = (r_ch == CH_W'(CHANNELS - 1));
    assign o_sts.out_free   = !r_ovalid || !i_out_stall;

    // read address runs one step ahead so r_rd always holds entry r_ch
    always_comb begin
        n_ch = r_ch;
        if (i_cmd.ch_clear) begin
            n_ch = '0;
        end else if (i_cmd.emit_load && !o_sts.ch_last) begin
            n_ch = r_ch + CH_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= CRC_INIT;
            r_seen   <= 1'b0;
            r_last_seq <= '0;
            r_ovalid <= 1'b0;
            r_pos    <= '0;
            r_ch     <= '0;
        end else begin
            if (i_cmd.crc_first) begin
                r_crc <= crc_feed(CRC_INIT, b);
            end else if (i_cmd.crc_next) begin
                r_crc <= crc_feed(r_crc, b);
            end else if (i_cmd.crc_init) begin
                r_crc <= CRC_INIT;
            end
            if (i_cmd.pos_clear) begin
                r_pos <= '0;
            end else if (i_cmd.store) begin
                r_pos <= r_pos + PW'(1);
            end
            if (i_cmd.accept) begin
                r_last_seq <= r_seq_frame;
                r_seen     <= 1'b1;
            end
            r_ch <= n_ch;
            if (i_cmd.emit_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers and strength memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            if (r_pos == '0) begin
                r_seq_frame <= b;
            end else if (r_pos[0]) begin
                r_lo <= b;
            end else begin
                r_mem[widx] <= {b, r_lo};
            end
        end
        if (i_cmd.lo_load) begin
            r_crc_lo <= b;
        end
        if (i_cmd.accept) begin
            r_time <= i_in_data.time_ms;
        end
        r_rd <= r_mem[n_ch];
        if (i_cmd.emit_load) begin
            r_out.frame_sequence   <= r_last_seq;
            r_out.channel_index    <= 4'(r_ch);
            r_out.channel_strength <= r_rd;
            r_out.received_time    <= r_time;
            r_out.last_channel     <= o_sts.ch_last;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

// ===== design/ir_frame_decoder_crc16_top.sv =====
// top level of the infrared frame decoder with crc-16 check
`timescale 1ns / 1ps
// usage
//   input channel: one received byte and a millisecond timestamp per transfer
//   (i_in_valid / o_in_stall / i_in_data). output channel: one channel strength
//   per transfer (o_out_valid / i_out_stall / o_out_data).
//   the block hunts for the sync pair a5 5a, collects the sequence byte, the
//   little-endian strengths and the little-endian crc-16/ccitt-false, and on a
//   good frame with a new sequence number sends one result per channel, the
//   last one flagged with last_channel.
// timing
//   while a frame is being received one byte is taken every cycle.
//   the first result of a good frame is loaded into the output register from
//   the emit state, entered once its final crc byte is taken; the burst then
//   runs one result per cycle while the receiver does not stall, limited by the
//   single read port of the strength memory and the output register.
//   input is stalled for the whole burst and opens again as soon as the
//   last result is loaded. bad or repeated frames give no results and no stall.
// reset: synchronous, active low: back to hunting, crc preset, no sequence seen, output empty
// stall: a stalled result holds in the output register, and the burst waits
module ir_frame_decoder_crc16_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ifd_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ifd_pkg::t_out o_out_data
);
    import ifd_pkg::*;

    // command and status between controller and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencing: hunt, sync, body, crc bytes, result burst
    ifd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // crc, frame storage and output register
    ifd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== design/ifd_checker.sv =====
// port-level assertions for the frame decoder and their bind
`timescale 1ns / 1ps
`include "ir_frame_decoder_crc16_top_macros.svh"

module ifd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input ifd_pkg::t_out o_out_data
);
    import ifd_pkg::*;

    // a stalled result holds
    `IFD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_data), "stalled result changed")

    // input stays closed until the last result of a burst is loaded
    `IFD_ASSERT_NOW(a_burst_stall, o_out_valid && !o_out_data.last_channel,
        o_in_stall, "input open during burst")

    // a taken result inside a burst is followed by the next channel
    `IFD_ASSERT_NEXT(a_ch_step,
        o_out_valid && !i_out_stall && !o_out_data.last_channel,
        o_out_valid && (o_out_data.channel_index ==
            ($past(o_out_data.channel_index) + 4'd1)),
        "channel index did not advance")

    // sequence and timestamp stay fixed within a burst
    `IFD_ASSERT_NEXT(a_frame_fixed, o_out_valid && !o_out_data.last_channel,
        $stable(o_out_data.frame_sequence) && $stable(o_out_data.received_time),
        "frame fields changed in burst")

endmodule

bind ir_frame_decoder_crc16_top ifd_checker u_ifd_checker (.*);

// ===== bench/ir_frame_decoder_crc16_top_tb.sv =====
// testbench for the infrared frame decoder: sync hunt, crc-16 check, per-channel result bursts
`timescale 1ns / 1ps

module ir_frame_decoder_crc16_top_tb;

    localparam int FRAME_BYTES = ifd_pkg::CRC_SPAN + 2;
    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_BYTES = 80;
    localparam int MAX_PRINTED = 50;

    // how strengths and timestamps of a frame are chosen
    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill_kind;

    // tracks the decoder state and holds the strengths still due on the output
    class frame_ledger;
        int             pos = 0;
        logic [15:0]    crc = ifd_pkg::CRC_INIT;
        logic [7:0]     body [ifd_pkg::STORE_LEN];
        logic [7:0]     crc_lo = 8'h00;
        logic [7:0]     last_seq = 8'h00;
        bit             seq_seen = 1'b0;
        ifd_pkg::t_out  pending_strengths [$];
        int             mismatches = 0;
        int             predicted = 0;

        // bit-serial crc-16/ccitt-false, msb first
        static function logic [15:0] crc_ccitt(logic [15:0] acc, logic [7:0] b);
            logic [15:0] c;
            c = acc;
            for (int k = 7; k >= 0; k--) begin
                if (c[15] ^ b[k]) begin
                    c = {c[14:0], 1'b0} ^ ifd_pkg::CRC_POLY;
                end else begin
                    c = {c[14:0], 1'b0};
                end
            end
            return c;
        endfunction

        task flag_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_PRINTED) begin
                $display("%0t ns mismatch: %s", $realtime, what);
            end
        endtask

        // one accepted byte: advance the parser, queue a burst on a good new frame
        function void take_byte(ifd_pkg::t_in item);
            logic [7:0]    b;
            logic [15:0]   got_crc;
            ifd_pkg::t_out r;
            b = item.data_byte;
            if (pos == 0) begin
                if (b == ifd_pkg::SYNC_FIRST) begin
                    crc = crc_ccitt(ifd_pkg::CRC_INIT, b);
                    pos = 1;
                end
            end else if (pos == 1) begin
                if (b == ifd_pkg::SYNC_SECOND) begin
                    crc = crc_ccitt(crc, b);
                    pos = 2;
                end else if (b == ifd_pkg::SYNC_FIRST) begin
                    crc = crc_ccitt(ifd_pkg::CRC_INIT, b);
                end else begin
                    crc = ifd_pkg::CRC_INIT;
                    pos = 0;
                end
            end else if (pos < ifd_pkg::CRC_SPAN) begin
                body[pos - 2] = b;
                crc = crc_ccitt(crc, b);
                pos++;
            end else if (pos == ifd_pkg::CRC_SPAN) begin
                crc_lo = b;
                pos++;
            end else begin
                pos = 0;
                got_crc = crc;
                crc = ifd_pkg::CRC_INIT;
                if (got_crc == {b, crc_lo} && !(seq_seen && body[0] == last_seq)) begin
                    last_seq = body[0];
                    seq_seen = 1'b1;
                    for (int ch = 0; ch < ifd_pkg::CHANNELS; ch++) begin
                        r.frame_sequence   = last_seq;
                        r.channel_index    = 4'(ch);
                        r.channel_strength = {body[2 + 2 * ch], body[1 + 2 * ch]};
                        r.received_time    = item.time_ms;
                        r.last_channel     = (ch == ifd_pkg::CHANNELS - 1);
                        pending_strengths.push_back(r);
                        predicted++;
                    end
                end
            end
        endfunction

        task check_strength(ifd_pkg::t_out got);
            ifd_pkg::t_out want;
            if (pending_strengths.size() == 0) begin
                flag_mismatch($sformatf("unexpected result seq %02h ch %0d",
                                        got.frame_sequence, got.channel_index));
                return;
            end
            want = pending_strengths.pop_front();
            if (got.frame_sequence !== want.frame_sequence) begin
                flag_mismatch($sformatf("frame_sequence %02h, want %02h",
                                        got.frame_sequence, want.frame_sequence));
            end
            if (got.channel_index !== want.channel_index) begin
                flag_mismatch($sformatf("channel_index %0d, want %0d",
                                        got.channel_index, want.channel_index));
            end
            if (got.channel_strength !== want.channel_strength) begin
                flag_mismatch($sformatf("channel_strength %04h, want %04h (ch %0d)",
                                        got.channel_strength, want.channel_strength,
                                        want.channel_index));
            end
            if (got.received_time !== want.received_time) begin
                flag_mismatch($sformatf("received_time %016h, want %016h",
                                        got.received_time, want.received_time));
            end
            if (got.last_channel !== want.last_channel) begin
                flag_mismatch($sformatf("last_channel %b, want %b (ch %0d)",
                                        got.last_channel, want.last_channel,
                                        want.channel_index));
            end
        endtask
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_stall;
    ifd_pkg::t_in  i_in_data = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    ifd_pkg::t_out o_out_data;

    frame_ledger ledger = new;
    bit          gaps_on = 1'b1;
    int          bytes_sent = 0;
    int          quiet = 0;

    ir_frame_decoder_crc16_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure, off while gaps are off
    always @(posedge i_clk) begin
        i_out_stall <= gaps_on && ($urandom_range(0, 99) < 33);
    end

    // watch both channels: feed the ledger, check results, catch a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                ledger.take_byte(i_in_data);
            end
            if (o_out_valid && !i_out_stall) begin
                ledger.check_strength(o_out_data);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("no transfer for %0d cycles", QUIET_LIMIT);
                $display("** ir_frame_decoder_crc16_top: FAILED **");
                $finish;
            end
        end
    end

    function automatic logic [63:0] pick_stamp(t_fill_kind mode);
        int r;
        r = $urandom_range(0, 15);
        case (mode)
            FILL_ZERO: return '0;
            FILL_ONES: return '1;
            default: begin
                if (r == 0) return '0;
                if (r == 1) return '1;
                return {$urandom, $urandom};
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_strength(t_fill_kind mode);
        int r;
        r = $urandom_range(0, 9);
        case (mode)
            FILL_ZERO: return 16'h0000;
            FILL_ONES: return 16'hFFFF;
            default: begin
                if (r == 0) return 16'h0000;
                if (r == 1) return 16'hFFFF;
                return 16'($urandom);
            end
        endcase
    endfunction

    // one byte transfer; random idle cycles ahead of it while gaps are on
    task automatic send_byte(input logic [7:0] b, input logic [63:0] stamp);
        while (gaps_on && $urandom_range(0, 99) < 33) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data.data_byte <= b;
        i_in_data.time_ms <= stamp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    // full frame with correct crc, optionally one flipped bit after the sync pair
    // and extra leading sync bytes
    task automatic send_frame(input logic [7:0] seq, input t_fill_kind strength_fill,
                              input t_fill_kind stamp_fill, input bit corrupt,
                              input int extra_sync);
        logic [7:0]  fb [FRAME_BYTES];
        logic [15:0] acc;
        logic [15:0] s;
        int          flip;
        fb[0] = ifd_pkg::SYNC_FIRST;
        fb[1] = ifd_pkg::SYNC_SECOND;
        fb[2] = seq;
        for (int ch = 0; ch < ifd_pkg::CHANNELS; ch++) begin
            s = pick_strength(strength_fill);
            fb[3 + 2 * ch] = s[7:0];
            fb[4 + 2 * ch] = s[15:8];
        end
        acc = ifd_pkg::CRC_INIT;
        for (int i = 0; i < ifd_pkg::CRC_SPAN; i++) begin
            acc = frame_ledger::crc_ccitt(acc, fb[i]);
        end
        fb[ifd_pkg::CRC_SPAN] = acc[7:0];
        fb[ifd_pkg::CRC_SPAN + 1] = acc[15:8];
        if (corrupt) begin
            flip = $urandom_range(2, FRAME_BYTES - 1);
            fb[flip] = fb[flip] ^ (8'h01 << $urandom_range(0, 7));
        end
        repeat (extra_sync) send_byte(ifd_pkg::SYNC_FIRST, pick_stamp(stamp_fill));
        for (int i = 0; i < FRAME_BYTES; i++) begin
            send_byte(fb[i], pick_stamp(stamp_fill));
        end
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_byte(8'($urandom_range(0, 255)), pick_stamp(FILL_RANDOM));
    endtask

    initial begin
        int          iter;
        int          pick;
        int          start_bytes;
        logic [7:0]  last_seq;
        logic [7:0]  seq;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bytes ignored while hunting, at the field extremes
        send_byte(8'h00, '0);
        send_byte(8'hFF, '1);
        send_byte(ifd_pkg::SYNC_SECOND, pick_stamp(FILL_RANDOM));
        // first frame carries sequence 0, same as the cleared last sequence
        send_frame(8'h00, FILL_ZERO, FILL_ZERO, 1'b0, 0);
        // repeated sequence, dropped
        send_frame(8'h00, FILL_RANDOM, FILL_RANDOM, 1'b0, 0);
        // all-ones strengths, sequence and timestamps
        send_frame(8'hFF, FILL_ONES, FILL_ONES, 1'b0, 0);
        // broken sync: a5 then something else
        send_byte(ifd_pkg::SYNC_FIRST, pick_stamp(FILL_RANDOM));
        send_byte(8'h00, pick_stamp(FILL_RANDOM));
        // repeated sync byte restarts the crc from the last a5
        send_frame(8'h01, FILL_RANDOM, FILL_RANDOM, 1'b0, 2);
        // bad crc, then the same sequence again which must still be accepted
        send_frame(8'h02, FILL_RANDOM, FILL_RANDOM, 1'b1, 0);
        send_frame(8'h02, FILL_RANDOM, FILL_RANDOM, 1'b0, 0);
        last_seq = 8'h02;

        // random part: mostly well-formed frames, some broken ones and noise
        start_bytes = bytes_sent;
        iter = 0;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            // three items with no idling on either side
            gaps_on = !(iter >= 3 && iter < 6);
            pick = $urandom_range(0, 99);
            seq = 8'($urandom_range(0, 255));
            if (pick < 55) begin
                send_frame(seq, FILL_RANDOM, FILL_RANDOM, 1'b0, 0);
                last_seq = seq;
            end else if (pick < 65) begin
                send_frame(last_seq, FILL_RANDOM, FILL_RANDOM, 1'b0, 0);
            end else if (pick < 75) begin
                send_frame(seq, FILL_RANDOM, FILL_RANDOM, 1'b1, 0);
            end else if (pick < 85) begin
                send_frame(seq, FILL_RANDOM, FILL_RANDOM, 1'b0, $urandom_range(1, 3));
                last_seq = seq;
            end else if (pick < 93) begin
                send_byte(ifd_pkg::SYNC_FIRST, pick_stamp(FILL_RANDOM));
                send_noise($urandom_range(1, 4));
            end else begin
                send_noise($urandom_range(1, 6));
            end
            iter++;
        end
        gaps_on = 1'b1;
        i_in_valid <= 1'b0;

        // drain the outstanding burst, then let the pipeline settle
        while (ledger.pending_strengths.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (ledger.mismatches == 0) begin
            $display("** ir_frame_decoder_crc16_top: PASSED **");
        end else begin
            $display("** ir_frame_decoder_crc16_top: FAILED **");
        end
        $finish;
    end

endmodule
